@@ rtl/core/chtm_pkg.sv @@
// package for the monotone convex hull trick min-cost block
// constants, payload structs, and status codes; no dependencies
`default_nettype none
package chtm_pkg;
   localparam int HullDepth = 1024;
   localparam int AddrBits = $clog2(HullDepth);
   localparam int CountBits = AddrBits + 1;
   localparam int ValueBits = 30;
   localparam int CostBits = 63;
   localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusSat = 2'd1;
   localparam logic [1:0] StatusFull = 2'd2;

   typedef struct packed {
      logic                 start_req;
      logic [ValueBits-1:0] item_height;
      logic [ValueBits-1:0] item_rate;
   } req_type;

   typedef struct packed {
      logic [CostBits-1:0] min_cost;
      logic [1:0]          status;
   } rsp_type;

   // hull memory entry
   typedef struct packed {
      logic [ValueBits-1:0] slope;
      logic [CostBits-1:0]  icpt;
   } line_type;
endpackage
`default_nettype wire

@@ rtl/core/chtm_if.sv @@
// valid/ready channel interfaces for request and response transactions
// depends on chtm_pkg
`default_nettype none
interface chtm_req_if (input wire logic clock);
   logic valid;
   logic ready;
   chtm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface chtm_rsp_if (input wire logic clock);
   logic valid;
   logic ready;
   chtm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/convex_hull_trick_min_dp.sv @@
// convex hull trick min-cost recurrence, top level: sequencer, hull memory, product compare
// a start or an empty hull skips the query; otherwise the query walks forward while
// the next line is no worse; then slope check with equal-slope pops, pop tests, push
// and output; next transaction is accepted the cycle after the result is registered,
// and the result waits there while it runs
// reset clears the hull count and query pointer; memory holds no reset value
`default_nettype none
module convex_hull_trick_min_dp (
   input wire logic  clock,
   input wire logic  reset,
   chtm_req_if.sink  req,
   chtm_rsp_if.source rsp
);
   localparam int AB = chtm_pkg::AddrBits;
   localparam int CB = chtm_pkg::CountBits;
   localparam int VB = chtm_pkg::ValueBits;
   localparam int KB = chtm_pkg::CostBits;

   typedef enum logic [3:0] {
      S_IDLE, S_QRD, S_QWAIT, S_QNEXT, S_QCMP, S_EQRD, S_EQCHK,
      S_PRD, S_PRD2, S_PCMP, S_PCMP2, S_PUSH, S_OUT
   } state_type;

   state_type state_ff;
   logic [CB-1:0] count_ff;
   logic [AB-1:0] qpos_ff;
   logic [VB-1:0] height_ff, rate_ff;
   logic [63:0] v_ff, cost_ff;
   logic [1:0] status_ff;
   chtm_pkg::line_type la_ff;
   logic rsp_valid_ff;
   chtm_pkg::rsp_type rsp_data_ff;

   logic ram_we;
   logic [AB-1:0] ram_waddr, ram_raddr;
   chtm_pkg::line_type ram_wdata, ram_rdata;
   logic cmp_le;
   logic [63:0] lv_prod, lv_sum, lv;
   logic signed [63:0] cx1, cx2;
   logic signed [31:0] cy1, cy2;

   chtm_ram u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   // pop test: line a = la_ff, line b = ram_rdata, new line = rate/cost
   always_comb begin
      cx1 = $signed(cost_ff) - $signed({1'b0, la_ff.icpt});
      cy1 = $signed({2'b0, la_ff.slope}) - $signed({2'b0, ram_rdata.slope});
      cx2 = $signed({1'b0, ram_rdata.icpt}) - $signed({1'b0, la_ff.icpt});
      cy2 = $signed({2'b0, la_ff.slope}) - $signed({2'b0, rate_ff});
   end

   chtm_cmp u_cmp (
      .clock(clock), .x1(cx1), .y1(cy1), .x2(cx2), .y2(cy2), .le(cmp_le)
   );

   // line value at the query height, saturating
   always_comb begin
      lv_prod = {34'b0, height_ff} * {34'b0, ram_rdata.slope};
      lv_sum = lv_prod + {1'b0, ram_rdata.icpt};
      lv = (lv_sum < lv_prod) ? '1 : lv_sum;
   end

   always_comb begin
      ram_raddr = '0;
      case (state_ff)
         S_QRD: ram_raddr = qpos_ff;
         S_QNEXT: ram_raddr = AB'(qpos_ff + 1'b1);
         S_EQRD: ram_raddr = AB'(count_ff - 1'b1);
         S_PRD: ram_raddr = AB'(count_ff - 2'd2);
         S_PRD2: ram_raddr = AB'(count_ff - 1'b1);
         default: ram_raddr = qpos_ff;
      endcase
      ram_we = (state_ff == S_PUSH) && (count_ff < CB'(chtm_pkg::HullDepth));
      ram_waddr = AB'(count_ff);
      ram_wdata.slope = rate_ff;
      ram_wdata.icpt = cost_ff[KB-1:0];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         qpos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  height_ff <= req.data.item_height;
                  rate_ff <= req.data.item_rate;
                  status_ff <= chtm_pkg::StatusOk;
                  cost_ff <= '0;
                  if (req.data.start_req || count_ff == '0) begin
                     count_ff <= req.data.start_req ? '0 : count_ff;
                     qpos_ff <= '0;
                     state_ff <= S_EQRD;
                  end else begin
                     if (CB'(qpos_ff) >= count_ff) qpos_ff <= AB'(count_ff - 1'b1);
                     state_ff <= S_QRD;
                  end
               end
            end
            S_QRD: state_ff <= S_QWAIT;
            S_QWAIT: begin
               v_ff <= lv;
               state_ff <= (CB'(qpos_ff) + 1'b1 < count_ff) ? S_QNEXT : S_QCMP;
            end
            S_QNEXT: state_ff <= S_QCMP;
            S_QCMP: begin
               if (CB'(qpos_ff) + 1'b1 < count_ff && !(lv > v_ff)) begin
                  v_ff <= lv;
                  qpos_ff <= qpos_ff + 1'b1;
                  if (CB'(qpos_ff) + 2'd2 < count_ff) begin
                     state_ff <= S_QNEXT;
                  end else begin
                     state_ff <= S_EQRD;
                     cost_ff <= (lv > 64'(chtm_pkg::CostMax)) ? 64'(chtm_pkg::CostMax) : lv;
                     status_ff <= (lv > 64'(chtm_pkg::CostMax)) ? chtm_pkg::StatusSat
                                                                 : chtm_pkg::StatusOk;
                  end
               end else begin
                  cost_ff <= (v_ff > 64'(chtm_pkg::CostMax)) ? 64'(chtm_pkg::CostMax) : v_ff;
                  status_ff <= (v_ff > 64'(chtm_pkg::CostMax)) ? chtm_pkg::StatusSat
                                                                : chtm_pkg::StatusOk;
                  state_ff <= S_EQRD;
               end
            end
            S_EQRD: state_ff <= (count_ff == '0) ? S_PUSH : S_EQCHK;
            S_EQCHK: begin
               if (ram_rdata.slope == rate_ff) begin
                  if (cost_ff[KB-1:0] < ram_rdata.icpt) begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= (count_ff == CB'(1)) ? S_PUSH : S_EQRD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else begin
                  state_ff <= (count_ff >= CB'(2)) ? S_PRD : S_PUSH;
               end
            end
            S_PRD: state_ff <= S_PRD2;
            S_PRD2: begin
               la_ff <= ram_rdata;
               state_ff <= S_PCMP;
            end
            S_PCMP: state_ff <= S_PCMP2;
            S_PCMP2: begin
               if (cmp_le) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= (count_ff >= CB'(3)) ? S_PRD : S_PUSH;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (count_ff >= CB'(chtm_pkg::HullDepth)) begin
                  status_ff <= chtm_pkg::StatusFull;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  if (CB'(qpos_ff) > count_ff) qpos_ff <= AB'(count_ff);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_data_ff.min_cost <= cost_ff[KB-1:0];
                  rsp_data_ff.status <= status_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/chtm_ram.sv @@
// hull line stack memory, one write and one registered read port
// depends on chtm_pkg
`default_nettype none
module chtm_ram (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [chtm_pkg::AddrBits-1:0] wr_addr,
   input  wire chtm_pkg::line_type           wr_data,
   input  wire logic [chtm_pkg::AddrBits-1:0] rd_addr,
   output chtm_pkg::line_type                rd_data
);
   chtm_pkg::line_type mem [chtm_pkg::HullDepth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/core/chtm_cmp.sv @@
// exact signed product compare x1*y1 <= x2*y2, partial products registered, sum and compare combinational
// x inputs are 64-bit and y inputs 32-bit signed differences; no package dependencies
`default_nettype none
module chtm_cmp (
   input  wire logic               clock,
   input  wire logic signed [63:0] x1,
   input  wire logic signed [31:0] y1,
   input  wire logic signed [63:0] x2,
   input  wire logic signed [31:0] y2,
   output logic                    le
);
   // split the 64-bit factor into signed high and unsigned low halves
   logic signed [63:0] p1_hi_ff, p1_lo_ff, p2_hi_ff, p2_lo_ff;
   logic signed [63:0] p1_hi_in, p1_lo_in, p2_hi_in, p2_lo_in;
   logic signed [96:0] s1, s2;

   always_comb begin
      p1_hi_in = $signed(x1[63:32]) * y1;
      p1_lo_in = $signed({1'b0, x1[31:0]}) * y1;
      p2_hi_in = $signed(x2[63:32]) * y2;
      p2_lo_in = $signed({1'b0, x2[31:0]}) * y2;
   end

   always_ff @(posedge clock) begin
      p1_hi_ff <= p1_hi_in;
      p1_lo_ff <= p1_lo_in;
      p2_hi_ff <= p2_hi_in;
      p2_lo_ff <= p2_lo_in;
   end

   always_comb begin
      s1 = ($signed({{1{p1_hi_ff[63]}}, p1_hi_ff}) <<< 32)
           + $signed({{33{p1_lo_ff[63]}}, p1_lo_ff});
      s2 = ($signed({{1{p2_hi_ff[63]}}, p2_hi_ff}) <<< 32)
           + $signed({{33{p2_lo_ff[63]}}, p2_lo_ff});
      le = (s1 <= s2);
   end
endmodule
`default_nettype wire

@@ bench/chtm_bench_pkg.sv @@
// testbench helpers for the convex hull trick block: expected-cost scoreboard class
// depends on chtm_pkg
`timescale 1ns / 100ps
package chtm_bench_pkg;

   class cost_scoreboard;
      logic [chtm_pkg::ValueBits-1:0] slope_mem [chtm_pkg::HullDepth];
      logic [chtm_pkg::CostBits-1:0] icpt_mem [chtm_pkg::HullDepth];
      int unsigned line_count;
      int unsigned query_pos;
      chtm_pkg::rsp_type pending_costs[$];
      int unsigned error_count;

      function new();
         line_count = 0;
         query_pos = 0;
         error_count = 0;
      endfunction

      function logic [63:0] eval_line(int unsigned k, logic [63:0] h);
         logic [63:0] p;
         logic [64:0] s;
         p = h * {34'd0, slope_mem[k]};
         s = {1'b0, p} + {2'b0, icpt_mem[k]};
         eval_line = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
      endfunction

      // true when the newest line c makes the top line b useless
      function bit top_dominated(logic [63:0] sc, logic [63:0] bc);
         logic signed [64:0] sa, sb, ba, bb, x1, y1, x2, y2;
         logic signed [130:0] lhs, rhs;
         sa = {35'd0, slope_mem[line_count-2]};
         sb = {35'd0, slope_mem[line_count-1]};
         ba = {2'b0, icpt_mem[line_count-2]};
         bb = {2'b0, icpt_mem[line_count-1]};
         x1 = $signed({1'b0, bc}) - ba;
         y1 = sa - sb;
         x2 = bb - ba;
         y2 = sa - $signed({1'b0, sc});
         lhs = x1 * y1;
         rhs = x2 * y2;
         top_dominated = lhs <= rhs;
      endfunction

      function bit add_line(logic [63:0] sc, logic [63:0] bc);
         while (line_count >= 1 && {34'd0, slope_mem[line_count-1]} == sc) begin
            if (bc < {1'b0, icpt_mem[line_count-1]}) line_count--;
            else return 1;
         end
         while (line_count >= 2) begin
            if (top_dominated(sc, bc)) line_count--;
            else break;
         end
         if (line_count >= chtm_pkg::HullDepth) return 0;
         slope_mem[line_count] = sc[chtm_pkg::ValueBits-1:0];
         icpt_mem[line_count] = bc[chtm_pkg::CostBits-1:0];
         line_count++;
         if (query_pos >= line_count) query_pos = line_count - 1;
         return 1;
      endfunction

      function void note_request(chtm_pkg::req_type r);
         logic [63:0] h, v, w, cost;
         chtm_pkg::rsp_type e;
         h = {34'd0, r.item_height};
         cost = 0;
         e.status = chtm_pkg::StatusOk;
         if (r.start_req) begin
            line_count = 0;
            query_pos = 0;
         end
         if (line_count != 0) begin
            if (query_pos >= line_count) query_pos = line_count - 1;
            v = eval_line(query_pos, h);
            while (query_pos + 1 < line_count) begin
               w = eval_line(query_pos + 1, h);
               if (w > v) break;
               v = w;
               query_pos++;
            end
            if (v > {1'b0, chtm_pkg::CostMax}) begin
               cost = {1'b0, chtm_pkg::CostMax};
               e.status = chtm_pkg::StatusSat;
            end else begin
               cost = v;
            end
         end else begin
            query_pos = 0;
         end
         if (!add_line({34'd0, r.item_rate}, cost)) e.status = chtm_pkg::StatusFull;
         e.min_cost = cost[chtm_pkg::CostBits-1:0];
         pending_costs.push_back(e);
      endfunction

      function void check_response(chtm_pkg::rsp_type got);
         chtm_pkg::rsp_type e;
         if (pending_costs.size() == 0) begin
            $display("%0t: unexpected response cost %0d status %0d", $time,
                     got.min_cost, got.status);
            error_count++;
            return;
         end
         e = pending_costs.pop_front();
         if (got.min_cost !== e.min_cost) begin
            $display("%0t: min_cost expected %0d actual %0d", $time, e.min_cost,
                     got.min_cost);
            error_count++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            error_count++;
         end
      endfunction
   endclass
endpackage

@@ bench/convex_hull_trick_min_dp_test.sv @@
// top-level testbench for convex_hull_trick_min_dp: directed and random problems,
// random idling and a long response stall; depends on chtm_pkg, chtm_if, chtm_bench_pkg
`timescale 1ns / 100ps
module convex_hull_trick_min_dp_test;

   localparam int WatchdogLimit = 200000;

   logic clock = 0;
   logic reset = 1;
   logic sending = 1;
   int unsigned idle_count = 0;
   logic hold_rsp = 0;
   chtm_bench_pkg::cost_scoreboard board;

   chtm_req_if req (clock);
   chtm_rsp_if rsp (clock);

   convex_hull_trick_min_dp u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) board.note_request(req.data);
      if (!reset && rsp.valid && rsp.ready) board.check_response(rsp.data);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls, with a long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(bit first, logic [29:0] height, logic [29:0] rate,
                            bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req.data <= '{start_req: first, item_height: height, item_rate: rate};
      req.valid <= 1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // one well-formed problem: nondecreasing heights, nonincreasing rates
   task automatic send_problem(int n, int span, bit use_gap);
      logic [29:0] h, r, lim;
      lim = 30'(span);
      h = 30'($urandom_range(0, span));
      r = 30'h3FFFFFFF - 30'($urandom_range(0, span));
      for (int i = 0; i < n; i++) begin
         send_item(i == 0, h, r, use_gap);
         if (h < 30'h3FFFFFFF - lim) h = h + 30'($urandom_range(0, span));
         if (r > lim) r = r - 30'($urandom_range(0, span));
      end
   endtask

   initial begin
      int sent;
      int span;
      board = new();
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // empty hull without a start, then extremes
      send_item(0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0);
      send_item(1, 0, 30'h3FFFFFFF, 0);
      send_item(0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0);
      send_item(0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0);
      send_item(0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0);
      send_item(0, 30'h3FFFFFFF, 0, 0);
      send_item(1, 5, 100, 0);
      send_item(0, 6, 100, 0);
      send_item(0, 7, 50, 0);
      send_item(0, 8, 50, 0);
      send_item(0, 9, 0, 0);
      // out of order
      send_item(0, 2, 70, 0);
      send_item(0, 30'h15555555, 30'h2AAAAAAA, 0);
      send_item(0, 30'h2AAAAAAA, 30'h15555555, 0);
      // stack full: strictly decreasing slopes on a convex curve
      for (int i = 0; i < 1030; i++)
         send_item(i == 0, 30'(i * (i + 1) / 2), 30'(1000000 - i), 0);
      // long response stall while requests keep coming
      hold_rsp = 1;
      send_problem(40, 1000, 0);
      sent = 0;
      while (sent < 400) begin
         span = int'(($urandom_range(0, 3) == 0) ? 32'h0FFFFFFF : $urandom_range(1, 2000));
         if ($urandom_range(0, 7) == 0) begin
            send_item(1'($urandom_range(0, 1)), 30'($urandom), 30'($urandom), 1);
            sent++;
         end else begin
            int n;
            n = $urandom_range(1, 30);
            send_problem(n, span, $urandom_range(0, 3) != 0);
            sent += n;
         end
      end
      req.valid <= 0;
      while (board.pending_costs.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
